// ===== hw/rtl/bdq_pkg.sv =====
// Package: shared constants and codes of the bounded deque.
package bdq_pkg;

	localparam int DEPTH_DEF  = 64;
	localparam int WORD_W     = 32;
	localparam int CAP_W      = 7;
	localparam int ACTION_W   = 3;
	localparam int STATUS_W   = 2;
	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

	typedef enum logic [ACTION_W-1:0] {
		ACT_PUSH_FRONT = 3'd0,
		ACT_PUSH_BACK  = 3'd1,
		ACT_POP_FRONT  = 3'd2,
		ACT_POP_BACK   = 3'd3,
		ACT_DUMP       = 3'd4
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

endpackage

// ===== hw/rtl/bdq_store.sv =====
// Word store of the deque: one write port, one read port with registered data.
module bdq_store #(
	parameter int DEPTH = bdq_pkg::DEPTH_DEF,
	parameter int IDX_W = 6
) (
	input  logic                               clk,
	input  logic                               wr_en,
	input  logic [IDX_W-1:0]                   wr_addr,
	input  logic signed [bdq_pkg::WORD_W-1:0]  wr_data,
	input  logic                               rd_en,
	input  logic [IDX_W-1:0]                   rd_addr,
	output logic signed [bdq_pkg::WORD_W-1:0]  rd_data
);
	import bdq_pkg::*;

	logic signed [WORD_W-1:0] mem [DEPTH];
	logic signed [WORD_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== hw/rtl/bdq_ctrl.sv =====
// Sequencer of the deque: pointers, count, capacity, dump walk and result register.
module bdq_ctrl #(
	parameter int DEPTH = bdq_pkg::DEPTH_DEF,
	parameter int IDX_W = 6,
	parameter int CNT_W = 7
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [bdq_pkg::ACTION_W-1:0]        s_action,
	input  logic signed [bdq_pkg::WORD_W-1:0]   s_value,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [bdq_pkg::STATUS_W-1:0]        m_status,
	output logic signed [bdq_pkg::WORD_W-1:0]   m_data,
	output logic                                m_last,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [bdq_pkg::CAP_W-1:0]           cfg_data,
	output logic                                wr_en,
	output logic [IDX_W-1:0]                    wr_addr,
	output logic signed [bdq_pkg::WORD_W-1:0]   wr_data,
	output logic                                rd_en,
	output logic [IDX_W-1:0]                    rd_addr,
	input  logic signed [bdq_pkg::WORD_W-1:0]   rd_data
);
	import bdq_pkg::*;

	localparam int SUM_W = IDX_W + 1;
	localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(DEPTH);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
	localparam logic [CAP_W-1:0] DEPTH_C = CAP_W'(DEPTH);

	typedef enum logic [1:0] {S_IDLE, S_POP, S_DUMP} state_t;

	state_t              state_q;
	logic [IDX_W-1:0]    head_q;
	logic [CNT_W-1:0]    count_q;
	logic [CAP_W-1:0]    cap_q;
	logic [IDX_W-1:0]    ptr_q;
	logic [CNT_W-1:0]    rem_q;
	logic                m_tvalid_q;
	logic [STATUS_W-1:0] m_status_q;
	logic [WORD_W-1:0]   m_data_q;
	logic                m_last_q;

	logic                out_free;
	logic                accept;
	action_t             act;
	logic [CAP_W-1:0]    lim;
	logic                full;
	logic                empty;
	logic [IDX_W-1:0]    off;
	logic [SUM_W-1:0]    sum;
	logic [IDX_W-1:0]    slot_off;
	logic [IDX_W-1:0]    head_inc;
	logic [IDX_W-1:0]    head_dec;
	logic [IDX_W-1:0]    ptr_inc;

	function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] p);
		return (p == LAST_IDX) ? '0 : p + 1'b1;
	endfunction

	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == S_IDLE) && out_free;
	assign accept   = s_tvalid && s_tready;
	assign act      = action_t'(s_action);
	assign cfg_ready = 1'b1;

	// capacity above the store depth acts as the depth
	assign lim   = (cap_q > DEPTH_C) ? DEPTH_C : cap_q;
	assign full  = CAP_W'(count_q) >= lim;
	assign empty = (count_q == '0);

	// slot of the back element (pop) or the next free back slot (push)
	assign off      = (act == ACT_PUSH_BACK) ? IDX_W'(count_q) : IDX_W'(count_q - 1'b1);
	assign sum      = {1'b0, head_q} + {1'b0, off};
	assign slot_off = (sum >= DEPTH_S) ? IDX_W'(sum - DEPTH_S) : IDX_W'(sum);
	assign head_inc = wrap_inc(head_q);
	assign head_dec = (head_q == '0) ? LAST_IDX : head_q - 1'b1;
	assign ptr_inc  = wrap_inc(ptr_q);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = head_dec;
		wr_data = s_value;
		rd_en   = 1'b0;
		rd_addr = head_q;
		if (accept) begin
			case (act)
				ACT_PUSH_FRONT: begin
					wr_en = !full;
				end
				ACT_PUSH_BACK: begin
					wr_en   = !full;
					wr_addr = slot_off;
				end
				ACT_POP_FRONT, ACT_DUMP: begin
					rd_en = !empty;
				end
				ACT_POP_BACK: begin
					rd_en   = !empty;
					rd_addr = slot_off;
				end
				default: begin
				end
			endcase
		end else if (state_q == S_DUMP && out_free && rem_q != CNT_W'(1)) begin
			rd_en   = 1'b1;
			rd_addr = ptr_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			head_q     <= '0;
			count_q    <= '0;
			cap_q      <= CAP_RESET;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				cap_q <= cfg_data;
			end
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (act)
							ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
								m_tvalid_q <= 1'b1;
								m_status_q <= full ? ST_FULL : ST_DONE;
								m_data_q   <= '0;
								m_last_q   <= 1'b1;
								if (!full) begin
									count_q <= count_q + 1'b1;
									if (act == ACT_PUSH_FRONT) begin
										head_q <= head_dec;
									end
								end
							end
							ACT_POP_FRONT, ACT_POP_BACK: begin
								if (empty) begin
									m_tvalid_q <= 1'b1;
									m_status_q <= ST_EMPTY;
									m_data_q   <= '0;
									m_last_q   <= 1'b1;
								end else begin
									count_q <= count_q - 1'b1;
									if (act == ACT_POP_FRONT) begin
										head_q <= head_inc;
									end
									state_q <= S_POP;
								end
							end
							ACT_DUMP: begin
								if (empty) begin
									m_tvalid_q <= 1'b1;
									m_status_q <= ST_EMPTY;
									m_data_q   <= '0;
									m_last_q   <= 1'b1;
								end else begin
									ptr_q   <= head_inc;
									rem_q   <= count_q;
									state_q <= S_DUMP;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_POP: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_status_q <= ST_DONE;
						m_data_q   <= rd_data;
						m_last_q   <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				S_DUMP: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_status_q <= ST_DONE;
						m_data_q   <= rd_data;
						m_last_q   <= (rem_q == CNT_W'(1));
						if (rem_q == CNT_W'(1)) begin
							state_q <= S_IDLE;
						end else begin
							ptr_q <= ptr_inc;
							rem_q <= rem_q - 1'b1;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_status = m_status_q;
	assign m_data   = m_data_q;
	assign m_last   = m_last_q;

endmodule

// ===== hw/rtl/bounded_deque_top.sv =====
// Top level of the bounded deque: stream ports, store and sequencer.
//
// Double-ended queue of signed 32-bit words in a circular store of DEPTH words.
// Input stream (s_*): one transfer is one action; s_tuser carries the action
// (push front, push back, pop front, pop back, dump) and s_tdata the word to push.
// Output stream (m_*): m_tuser carries status (done, full, empty), m_tdata the
// popped or dumped word (zero otherwise), m_tlast marks the final result of an action.
// Config channel (cfg_*): writes the capacity; always ready, write only while idle.
// Results: a push or refused action shows its result in the cycle after the input
// transfer; a pop first reads the store into its read register, then the result register.
// Actions are taken one at a time: a push, a pop and a dump each finish before the next
// is taken, the dump walk paced by the single read port of the store.
// Undefined actions are taken and dropped without result.
// An action is taken only while the result register is empty or drains that cycle.
// Stall: a held m_tready freezes the result register and the dump walk; the input
// is not taken until the current action has placed its last result.
// Reset (arst_n low): empty deque, head at zero, capacity 64; the store is not
// cleared, since no entry is read before it is written.
module bounded_deque_top #(
	parameter int DEPTH = bdq_pkg::DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] value
	input  logic [7:0]  s_tuser,   // [2:0] action, rest zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] data
	output logic [7:0]  m_tuser,   // [1:0] status, rest zero
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data   // [6:0] capacity, rest ignored
);
	import bdq_pkg::*;

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	// store access from the sequencer
	logic                     wr_en;
	logic [IDX_W-1:0]         wr_addr;
	logic signed [WORD_W-1:0] wr_data;
	logic                     rd_en;
	logic [IDX_W-1:0]         rd_addr;
	logic signed [WORD_W-1:0] rd_data;

	logic [STATUS_W-1:0]      status;
	logic signed [WORD_W-1:0] data;

	bdq_store #(
		.DEPTH (DEPTH),
		.IDX_W (IDX_W)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	bdq_ctrl #(
		.DEPTH (DEPTH),
		.IDX_W (IDX_W),
		.CNT_W (CNT_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_action  (s_tuser[ACTION_W-1:0]),
		.s_value   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_status  (status),
		.m_data    (data),
		.m_last    (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data[CAP_W-1:0]),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data)
	);

	assign m_tdata = data;
	assign m_tuser = {{(8 - STATUS_W){1'b0}}, status};

endmodule
